FILE: rtl/elg_pkg.sv
// shared types, constants and codes of the elgamal decryption block
package elg_pkg;

	// default word width of modulus, exponent and ciphertext values
	localparam int WORD_BITS_DEF = 32;

	// configuration register index width and register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 2'd1;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_INIT_INV,
		ST_INV_CHK,
		ST_INV_MUL,
		ST_INV_SQR,
		ST_PWR_CHK,
		ST_PWR_MUL,
		ST_PWR_SQR,
		ST_FINAL
	} state_t;

	// operand pairs of the modular multiplier
	typedef enum logic [1:0] {
		SEL_ACC_BASE,
		SEL_BASE_BASE,
		SEL_C2_ACC
	} mul_sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic     load_item;
		logic     red_step;
		logic     init_inv;
		logic     init_pow;
		logic     mul_load;
		mul_sel_t mul_sel;
		logic     mul_step;
		logic     write_acc;
		logic     write_base;
		logic     shift_exp;
		logic     emit_mul;
		logic     emit_zero;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic mod_zero;
		logic exp_zero;
		logic exp_lsb;
		logic step_last;
	} status_t;

endpackage

FILE: rtl/elg_ctrl.sv
// controller state machine sequencing reduction, two exponentiations and final multiply
module elg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  elg_pkg::status_t status,
	output logic             busy,
	output elg_pkg::cmd_t    cmd
);
	import elg_pkg::*;

	state_t state_q;
	state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && !status.mod_zero) state_next = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (status.step_last) state_next = ST_INIT_INV;
			end
			ST_INIT_INV: state_next = ST_INV_CHK;
			ST_INV_CHK: begin
				if (status.exp_zero) state_next = ST_PWR_CHK;
				else if (status.exp_lsb) state_next = ST_INV_MUL;
				else state_next = ST_INV_SQR;
			end
			ST_INV_MUL: begin
				if (status.step_last) state_next = ST_INV_SQR;
			end
			ST_INV_SQR: begin
				if (status.step_last) state_next = ST_INV_CHK;
			end
			ST_PWR_CHK: begin
				if (status.exp_zero) state_next = ST_FINAL;
				else if (status.exp_lsb) state_next = ST_PWR_MUL;
				else state_next = ST_PWR_SQR;
			end
			ST_PWR_MUL: begin
				if (status.step_last) state_next = ST_PWR_SQR;
			end
			ST_PWR_SQR: begin
				if (status.step_last) state_next = ST_PWR_CHK;
			end
			ST_FINAL: begin
				if (status.step_last) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (status.mod_zero) cmd.emit_zero = 1'b1;
					else cmd.load_item = 1'b1;
				end
			end
			ST_REDUCE: cmd.red_step = 1'b1;
			ST_INIT_INV: cmd.init_inv = 1'b1;
			ST_INV_CHK, ST_PWR_CHK: begin
				if (status.exp_zero) begin
					if (state_q == ST_INV_CHK) begin
						cmd.init_pow = 1'b1;
					end else begin
						cmd.mul_load = 1'b1;
						cmd.mul_sel  = SEL_C2_ACC;
					end
				end else begin
					cmd.mul_load = 1'b1;
					cmd.mul_sel  = status.exp_lsb ? SEL_ACC_BASE : SEL_BASE_BASE;
				end
			end
			ST_INV_MUL, ST_PWR_MUL: begin
				cmd.mul_step = 1'b1;
				if (status.step_last) begin
					cmd.write_acc = 1'b1;
					cmd.mul_load  = 1'b1;
					cmd.mul_sel   = SEL_BASE_BASE;
				end
			end
			ST_INV_SQR, ST_PWR_SQR: begin
				cmd.mul_step = 1'b1;
				if (status.step_last) begin
					cmd.write_base = 1'b1;
					cmd.shift_exp  = 1'b1;
				end
			end
			ST_FINAL: begin
				cmd.mul_step = 1'b1;
				if (status.step_last) cmd.emit_mul = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

endmodule

FILE: rtl/elg_datapath.sv
// datapath: modular reduction, shift-and-add modular multiplier and exponent registers
module elg_datapath #(
	parameter int WORD_BITS = elg_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  elg_pkg::cmd_t        cmd,
	output elg_pkg::status_t     status,
	input  logic [WORD_BITS-1:0] modulus,
	input  logic [WORD_BITS-1:0] exponent,
	input  logic [WORD_BITS-1:0] cipher_first,
	input  logic [WORD_BITS-1:0] cipher_second,
	output logic [WORD_BITS-1:0] plain_value,
	output logic                 done
);
	import elg_pkg::*;

	localparam int CNT_BITS = $clog2(WORD_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

	// (a + b) mod m for a, b below m
	function automatic logic [WORD_BITS-1:0] add_mod(
		input logic [WORD_BITS-1:0] a,
		input logic [WORD_BITS-1:0] b,
		input logic [WORD_BITS-1:0] m
	);
		logic [WORD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) s = s - {1'b0, m};
		return s[WORD_BITS-1:0];
	endfunction

	// one restoring remainder step: shift in a bit, subtract if not below m
	function automatic logic [WORD_BITS-1:0] red_bit(
		input logic [WORD_BITS-1:0] r,
		input logic                 b,
		input logic [WORD_BITS-1:0] m
	);
		logic [WORD_BITS:0] t;
		t = {r, b};
		if (t >= {1'b0, m}) t = t - {1'b0, m};
		return t[WORD_BITS-1:0];
	endfunction

	logic [CNT_BITS-1:0]  cnt_q;
	logic [WORD_BITS-1:0] acc_q, base_q, exp_q;
	logic [WORD_BITS-1:0] src1_q, src2_q, rem1_q, rem2_q;
	logic [WORD_BITS-1:0] ma_q, mb_q, mr_q;
	logic [WORD_BITS-1:0] plain_q;
	logic                 done_q;

	logic [WORD_BITS-1:0] one_val;
	logic [WORD_BITS-1:0] mr_next, ma_next;
	logic [WORD_BITS-1:0] op_a, op_b;

	// one mod p, which is zero when p is one
	assign one_val = (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

	// multiplier step: add multiplicand on a set bit, double multiplicand
	assign mr_next = mb_q[0] ? add_mod(mr_q, ma_q, modulus) : mr_q;
	assign ma_next = add_mod(ma_q, ma_q, modulus);

	// multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			SEL_ACC_BASE: begin
				op_a = base_q;
				op_b = acc_q;
			end
			SEL_BASE_BASE: begin
				op_a = base_q;
				op_b = base_q;
			end
			SEL_C2_ACC: begin
				op_a = rem2_q;
				op_b = acc_q;
			end
			default: begin
				op_a = base_q;
				op_b = acc_q;
			end
		endcase
	end

	// step counter and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_mul || cmd.emit_zero;
			if (cmd.load_item || cmd.mul_load) cnt_q <= '0;
			else if (cmd.red_step || cmd.mul_step) cnt_q <= cnt_q + CNT_BITS'(1);
		end
	end

	// reduction lanes for both ciphertext components
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			src1_q <= cipher_first;
			src2_q <= cipher_second;
			rem1_q <= '0;
			rem2_q <= '0;
		end else if (cmd.red_step) begin
			src1_q <= {src1_q[WORD_BITS-2:0], 1'b0};
			src2_q <= {src2_q[WORD_BITS-2:0], 1'b0};
			rem1_q <= red_bit(rem1_q, src1_q[WORD_BITS-1], modulus);
			rem2_q <= red_bit(rem2_q, src2_q[WORD_BITS-1], modulus);
		end
	end

	// modular multiplier registers
	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			ma_q <= op_a;
			mb_q <= op_b;
			mr_q <= '0;
		end else if (cmd.mul_step) begin
			ma_q <= ma_next;
			mb_q <= {1'b0, mb_q[WORD_BITS-1:1]};
			mr_q <= mr_next;
		end
	end

	// square-and-multiply working registers
	always_ff @(posedge clk) begin
		if (cmd.init_inv) begin
			acc_q  <= one_val;
			base_q <= rem1_q;
			exp_q  <= modulus - WORD_BITS'(2);
		end else if (cmd.init_pow) begin
			acc_q  <= one_val;
			base_q <= acc_q;
			exp_q  <= exponent;
		end else begin
			if (cmd.write_acc) acc_q <= mr_next;
			if (cmd.write_base) base_q <= mr_next;
			if (cmd.shift_exp) exp_q <= {1'b0, exp_q[WORD_BITS-1:1]};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit_mul) plain_q <= mr_next;
		else if (cmd.emit_zero) plain_q <= '0;
	end

	assign status.mod_zero  = (modulus == '0);
	assign status.exp_zero  = (exp_q == '0);
	assign status.exp_lsb   = exp_q[0];
	assign status.step_last = (cnt_q == CNT_LAST);

	assign plain_value = plain_q;
	assign done        = done_q;

endmodule

FILE: rtl/elgamal_decrypt_top.sv
// top level of the elgamal decryption block: configuration registers, controller, datapath
//
// One ciphertext pair is taken when start is high and busy is low; the plaintext
// appears on plain_value for exactly one cycle with done high, and the receiver
// cannot stall it. One item is worked on at a time. Both inputs are first reduced
// mod p in a bit-serial remainder unit; two exponentiations follow (with p-2 and
// then with x), and then a final multiply by the reduced c2. A shift-and-add
// modular multiplier serves every square and multiply. With p zero the result
// is zero in the cycle after acceptance. Configuration beats are always
// taken (cfg_ready is high) and must only arrive while the block is idle.
module elgamal_decrypt_top #(
	parameter int WORD_BITS = elg_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [WORD_BITS-1:0]             cipher_first,
	input  logic [WORD_BITS-1:0]             cipher_second,
	output logic                             done,
	output logic [WORD_BITS-1:0]             plain_value,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [elg_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [WORD_BITS-1:0]             cfg_data
);
	import elg_pkg::*;

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] exponent_q;
	cmd_t                 cmd;
	status_t              status;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= WORD_BITS'(3);
			exponent_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODULUS:  modulus_q  <= cfg_data;
				REG_EXPONENT: exponent_q <= cfg_data;
				default: ;
			endcase
		end
	end

	elg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	elg_datapath #(
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.modulus       (modulus_q),
		.exponent      (exponent_q),
		.cipher_first  (cipher_first),
		.cipher_second (cipher_second),
		.plain_value   (plain_value),
		.done          (done)
	);

	// an accepted item with a nonzero modulus keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && modulus_q != '0) |=> busy)
		else $error("accepted item did not start work");

	// the result beat comes out only once the sequence is finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	// with a nonzero modulus, a result is always a residue of the modulus
	a_done_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && modulus_q != '0) |-> (plain_value < modulus_q))
		else $error("result not reduced mod p");

	// a zero modulus gives a zero result
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && modulus_q == '0) |-> (plain_value == '0))
		else $error("nonzero result with zero modulus");

endmodule

FILE: tb/sv/tb_top.sv
// testbench of elgamal_decrypt_top: directed and random ciphertext pairs checked against a predictor
`timescale 1ns / 1ps

module tb_top;

	import elg_pkg::*;

	localparam int WORD_BITS = WORD_BITS_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 4400;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 15;

	// indexes past the last register, writes there must be ignored
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

	localparam logic [WORD_BITS-1:0] WORD_MAX = '1;
	localparam logic [WORD_BITS-1:0] PRIME_TOP = 32'd4294967291;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct {
		word_t c1;
		word_t c2;
		word_t plain;
	} plain_item_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	word_t                   cipher_first;
	word_t                   cipher_second;
	logic                    done;
	word_t                   plain_value;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	word_t                   cfg_data;

	// predictor copy of the configuration, reset values
	word_t modulus_now = 32'd3;
	word_t exponent_now = '0;

	plain_item_t plain_expected[$];
	int          mismatch_count = 0;
	int          stall_cycles = 0;
	bit          idling_on = 1'b1;

	elgamal_decrypt_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cipher_first (cipher_first),
		.cipher_second(cipher_second),
		.done         (done),
		.plain_value  (plain_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// (a * b) mod m, m nonzero
	function automatic word_t mod_product(word_t a, word_t b, word_t m);
		longint unsigned prod;
		prod = longint'(a) * longint'(b);
		return word_t'(prod % longint'(m));
	endfunction

	// square-and-multiply, m nonzero
	function automatic word_t mod_power(word_t base, word_t e, word_t m);
		word_t acc;
		word_t run;
		acc = word_t'(1) % m;
		run = base % m;
		while (e != '0) begin
			if (e[0])
				acc = mod_product(acc, run, m);
			run = mod_product(run, run, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	// plaintext c2 * (c1^(p-2))^x mod p under the current registers
	function automatic word_t decrypt_plain(word_t c1, word_t c2);
		word_t inverse;
		word_t mask;
		if (modulus_now == '0)
			return '0;
		inverse = mod_power(c1 % modulus_now, modulus_now - word_t'(2), modulus_now);
		mask = mod_power(inverse, exponent_now, modulus_now);
		return mod_product(c2, mask, modulus_now);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// one ciphertext beat; entered and left at a falling edge
	task automatic send_pair(input word_t c1, input word_t c2);
		plain_item_t item;
		if (idling_on && $urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 4)) @(negedge clk);
		cipher_first = c1;
		cipher_second = c2;
		start = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		item.c1 = c1;
		item.c2 = c2;
		item.plain = decrypt_plain(c1, c2);
		plain_expected.push_back(item);
		@(negedge clk);
		start = 1'b0;
		cipher_first = $urandom();
		cipher_second = $urandom();
	endtask

	// wait until every result is in and the block is idle
	task automatic wait_drained();
		while (plain_expected.size() != 0 || busy !== 1'b0)
			@(negedge clk);
	endtask

	// one configuration beat; caller makes sure the block is idle
	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input word_t value);
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == REG_MODULUS)
			modulus_now = value;
		else if (idx == REG_EXPONENT)
			exponent_now = value;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_index = $urandom();
		cfg_data = $urandom();
	endtask

	task automatic set_key(input word_t p, input word_t x);
		wait_drained();
		cfg_write(REG_MODULUS, p);
		cfg_write(REG_EXPONENT, x);
	endtask

	// reset values: p = 3, x = 0, so the result is c2 mod 3
	task automatic test_reset_defaults();
		send_pair('0, WORD_MAX);
		send_pair(WORD_MAX, '0);
		send_pair(32'd5, 32'd7);
	endtask

	// largest 32-bit prime with the widest exponent, c1 zero mod p among them
	task automatic test_field_extremes();
		set_key(PRIME_TOP, WORD_MAX);
		send_pair('0, WORD_MAX);
		send_pair(PRIME_TOP, 32'h1234_5678);
		send_pair(WORD_MAX, WORD_MAX);
		send_pair(32'd1, '0);
		send_pair(PRIME_TOP - 1, 32'hA5A5_5A5A);
	endtask

	// exponent zero gives c2 mod p, also for c1 zero since 0^0 counts as 1
	task automatic test_exponent_zero();
		set_key(PRIME_TOP, '0);
		send_pair('0, WORD_MAX);
		send_pair(32'hDEAD_BEEF, 32'hFFFF_FFFC);
		send_pair(PRIME_TOP, 32'd17);
	endtask

	// modulus zero, one, two and non-prime moduli are evaluated literally
	task automatic test_degenerate_moduli();
		word_t moduli[5];
		moduli = '{32'd0, 32'd1, 32'd2, 32'd4, WORD_MAX};
		foreach (moduli[i]) begin
			set_key(moduli[i], 32'h8000_0001);
			send_pair($urandom(), $urandom());
			send_pair(WORD_MAX, WORD_MAX);
		end
	endtask

	// writes to indexes past the register list leave the key alone
	task automatic test_spare_index();
		set_key(32'd65521, 32'd12345);
		cfg_write(REG_SPARE_LO, 32'd7);
		cfg_write(REG_SPARE_HI, '0);
		send_pair(32'd3, 32'd99);
		send_pair(32'd65521, WORD_MAX);
	endtask

	function automatic word_t pick_modulus();
		word_t primes[8];
		primes = '{32'd3, 32'd5, 32'd251, 32'd65521, 32'd1000000007,
			32'd2147483647, 32'd4294967279, PRIME_TOP};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return primes[$urandom_range(0, 7)];
			5, 6:          return $urandom() | 32'h8000_0001;
			7, 8:          return $urandom();
			default:       return $urandom_range(0, 20);
		endcase
	endfunction

	function automatic word_t pick_exponent();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return WORD_MAX;
			2, 3, 4: return $urandom() >> $urandom_range(1, 31);
			default: return $urandom();
		endcase
	endfunction

	function automatic word_t pick_first();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return modulus_now;
			2:       return modulus_now * word_t'($urandom_range(2, 5));
			3:       return modulus_now - 1;
			4:       return 32'd1;
			5:       return WORD_MAX;
			default: return $urandom();
		endcase
	endfunction

	function automatic word_t pick_second();
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return WORD_MAX;
			2:       return modulus_now;
			default: return $urandom();
		endcase
	endfunction

	// random keys per phase, random pairs within; no idling in the last phases
	task automatic test_random_pairs();
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph >= RANDOM_PHASES - 2)
				idling_on = 1'b0;
			set_key(pick_modulus(), pick_exponent());
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 9) == 0)
					wait_drained();
				send_pair(pick_first(), pick_second());
			end
		end
	endtask

	// result check
	always @(posedge clk) begin : result_check
		plain_item_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (plain_expected.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing pending", plain_value));
			end else begin
				want = plain_expected.pop_front();
				if (plain_value !== want.plain)
					report_mismatch($sformatf("c1=%h c2=%h plain_value=%h, want %h",
						want.c1, want.c2, plain_value, want.plain));
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (start && busy === 1'b0) || done === 1'b1
				|| (cfg_valid && cfg_ready === 1'b1)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[%0t] watchdog: no progress for %0d cycles", $realtime, STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cipher_first = '0;
		cipher_second = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_field_extremes();
		test_exponent_zero();
		test_degenerate_moduli();
		test_spare_index();
		test_random_pairs();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (plain_expected.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", plain_expected.size()));
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
